// ===== hw/rtl/ucgr_pkg.sv =====
// ucgr_pkg: shared constants, codes and queue entry type of the glyph renderer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ucgr_pkg;

	// default sizes of the glyph memory
	localparam int DEF_MAX_GLYPH_ROWS = 32;
	localparam int DEF_GLYPH_COUNT    = 256;

	// rows per drawn glyph never exceed this
	localparam int ROW_CAP = 32;

	// operation codes of an input item
	localparam logic [1:0] OP_LOAD_ROW = 2'd0;
	localparam logic [1:0] OP_BEGIN    = 2'd1;
	localparam logic [1:0] OP_TEXT     = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd1;

	localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd16;
	localparam logic [12:0] RST_SCREEN_WIDTH = 13'd640;

	// job queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	// one job: either a font row write or a glyph to draw
	typedef struct packed {
		logic        is_write;
		logic [7:0]  code;      // glyph number
		logic [4:0]  row;       // row of a write, zero for a draw
		logic [7:0]  data;      // row bits of a write
		logic [11:0] x;
		logic [11:0] y;
		logic [31:0] color;
		logic [5:0]  height;    // rows to draw, never zero for a draw
	} q_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ucgr_ifs.sv =====
// ucgr_ifs: valid/ready channel interfaces of the glyph renderer
// text input, row output and configuration write; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ucgr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  glyph_index;
	logic [4:0]  glyph_row;
	logic [7:0]  font_row_bits;
	logic [11:0] start_x;
	logic [11:0] start_y;
	logic [31:0] text_color;
	logic [7:0]  text_byte;
	logic        end_of_text;

	modport source(output valid, op, glyph_index, glyph_row, font_row_bits, start_x,
		start_y, text_color, text_byte, end_of_text, input ready);
	modport sink(input valid, op, glyph_index, glyph_row, font_row_bits, start_x,
		start_y, text_color, text_byte, end_of_text, output ready);
endinterface

interface ucgr_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [12:0] pixel_y;
	logic [7:0]  row_bits;
	logic [31:0] pixel_color;
	logic        last_row;

	modport source(output valid, pixel_x, pixel_y, row_bits, pixel_color, last_row,
		input ready);
	modport sink(input valid, pixel_x, pixel_y, row_bits, pixel_color, last_row,
		output ready);
endinterface

interface ucgr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ucgr_front.sv =====
// ucgr_front: accepts items, holds cursor and utf-8 state and configuration,
// and pushes font writes and glyph draws into the job queue; uses ucgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucgr_front import ucgr_pkg::*; #(
	parameter int MAX_GLYPH_ROWS = DEF_MAX_GLYPH_ROWS
) (
	input  wire        clk,
	input  wire        arst_n,
	ucgr_in_if.sink    text_in,
	ucgr_cfg_if.sink   cfg,
	input  wire        q_ready,
	output logic       q_push,
	output q_entry_t   q_entry
);

	localparam int HCAP = (MAX_GLYPH_ROWS < ROW_CAP) ? MAX_GLYPH_ROWS : ROW_CAP;

	logic [5:0]  glyph_height_q;
	logic [12:0] screen_width_q;
	logic [12:0] cursor_x_q, cursor_x_d;
	logic [11:0] cursor_y_q, cursor_y_d;
	logic [31:0] draw_color_q, draw_color_d;
	logic        lead_pending_q, lead_pending_d;
	logic [7:0]  lead_byte_q, lead_byte_d;
	logic        string_done_q, string_done_d;

	logic        accept;
	logic [5:0]  h_eff;
	logic [13:0] clip_sum;
	logic        clip;
	logic [4:0]  hi;
	logic [5:0]  lo;
	logic        cyr_ok;
	logic [7:0]  cyr_code;
	logic [7:0]  b;

	assign text_in.ready = q_ready;
	assign cfg.ready     = 1'b1;
	assign accept        = text_in.valid && q_ready;
	assign b             = text_in.text_byte;

	assign h_eff    = (glyph_height_q > 6'(HCAP)) ? 6'(HCAP) : glyph_height_q;
	assign clip_sum = {1'b0, cursor_x_q} + 14'd8;
	assign clip     = clip_sum > {1'b0, screen_width_q};

	// d0/d1 pairs map onto code page glyphs
	assign hi     = lead_byte_q[4:0];
	assign lo     = b[5:0];
	assign cyr_ok = (hi == 5'd16) || (hi == 5'd17);
	always_comb begin
		if (lo < 6'd16) begin
			cyr_code = (lo == 6'd1 && hi == 5'd16) ? 8'd240 : 8'd224 + {2'b00, lo};
		end else begin
			cyr_code = (lo == 6'd17 && hi == 5'd17) ? 8'd241 : 8'd128 + {2'b00, lo} - 8'd16;
		end
	end

	always_comb begin
		cursor_x_d     = cursor_x_q;
		cursor_y_d     = cursor_y_q;
		draw_color_d   = draw_color_q;
		lead_pending_d = lead_pending_q;
		lead_byte_d    = lead_byte_q;
		string_done_d  = string_done_q;
		q_push         = 1'b0;
		q_entry.is_write = 1'b0;
		q_entry.code     = b;
		q_entry.row      = '0;
		q_entry.data     = text_in.font_row_bits;
		q_entry.x        = cursor_x_q[11:0];
		q_entry.y        = cursor_y_q;
		q_entry.color    = draw_color_q;
		q_entry.height   = h_eff;
		if (accept) begin
			case (text_in.op)
				OP_LOAD_ROW: begin
					if (32'(text_in.glyph_row) < MAX_GLYPH_ROWS) begin
						q_push           = 1'b1;
						q_entry.is_write = 1'b1;
						q_entry.code     = text_in.glyph_index;
						q_entry.row      = text_in.glyph_row;
					end
				end
				OP_BEGIN: begin
					cursor_x_d     = {1'b0, text_in.start_x};
					cursor_y_d     = text_in.start_y;
					draw_color_d   = text_in.text_color;
					lead_pending_d = 1'b0;
					lead_byte_d    = '0;
					string_done_d  = 1'b0;
				end
				OP_TEXT: begin
					if (!string_done_q) begin
						if (lead_pending_q) begin
							// continuation byte, never clipped
							lead_pending_d = 1'b0;
							q_entry.code   = cyr_code;
							q_push         = cyr_ok && (h_eff != '0);
							cursor_x_d     = cursor_x_q + 13'd8;
							if (text_in.end_of_text) string_done_d = 1'b1;
						end else if (clip) begin
							string_done_d = 1'b1;
						end else if (b[7:5] == 3'b110) begin
							if (text_in.end_of_text) begin
								string_done_d = 1'b1;
							end else begin
								lead_pending_d = 1'b1;
								lead_byte_d    = b;
							end
						end else if (b == 8'd0) begin
							string_done_d = 1'b1;
						end else begin
							// high bytes alone draw nothing but advance
							q_push     = !b[7] && (h_eff != '0);
							cursor_x_d = cursor_x_q + 13'd8;
							if (text_in.end_of_text) string_done_d = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_height_q <= RST_GLYPH_HEIGHT;
			screen_width_q <= RST_SCREEN_WIDTH;
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			draw_color_q   <= '0;
			lead_pending_q <= 1'b0;
			lead_byte_q    <= '0;
			string_done_q  <= 1'b1;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_GLYPH_HEIGHT: glyph_height_q <= cfg.data[5:0];
					REG_SCREEN_WIDTH: screen_width_q <= cfg.data;
					default: begin
					end
				endcase
			end
			cursor_x_q     <= cursor_x_d;
			cursor_y_q     <= cursor_y_d;
			draw_color_q   <= draw_color_d;
			lead_pending_q <= lead_pending_d;
			lead_byte_q    <= lead_byte_d;
			string_done_q  <= string_done_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ucgr_queue.sv =====
// ucgr_queue: small job fifo between front and back
// uses q_entry_t and depth constants from ucgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucgr_queue import ucgr_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  q_entry_t   push_entry,
	output logic       not_full,
	input  wire        pop,
	output logic       not_empty,
	output q_entry_t   head
);

	q_entry_t             slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;

	assign not_full  = count_q != (Q_PTR_W + 1)'(Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ucgr_back.sv =====
// ucgr_back: glyph memory and row sequencer; pops jobs, writes font rows and
// streams one glyph row per cycle, row_out stalls aside, into the output register; uses ucgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucgr_back import ucgr_pkg::*; #(
	parameter int MAX_GLYPH_ROWS = DEF_MAX_GLYPH_ROWS,
	parameter int GLYPH_COUNT    = DEF_GLYPH_COUNT
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        q_valid,
	input  q_entry_t   q_entry,
	output logic       q_pop,
	ucgr_out_if.source row_out
);

	localparam int DEPTH  = GLYPH_COUNT * MAX_GLYPH_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [7:0]        store_q [DEPTH];

	logic              job_active_q;
	logic [4:0]        row_q;
	logic [5:0]        job_h_q;
	logic [ADDR_W-1:0] base_q;
	logic [11:0]       job_x_q;
	logic [11:0]       job_y_q;
	logic [31:0]       job_color_q;

	logic              v_s1;
	logic [7:0]        rdata_s1;
	logic [11:0]       x_s1;
	logic [12:0]       y_s1;
	logic [31:0]       color_s1;
	logic              last_s1;

	logic              issue;
	logic              last_issue;
	logic [ADDR_W-1:0] ent_addr;
	logic [ADDR_W-1:0] raddr;

	assign issue      = job_active_q && (!v_s1 || row_out.ready);
	assign last_issue = {1'b0, row_q} == (job_h_q - 6'd1);
	assign q_pop      = q_valid && (!job_active_q || (issue && last_issue));
	assign ent_addr   = ADDR_W'(q_entry.code) * ADDR_W'(MAX_GLYPH_ROWS)
		+ ADDR_W'(q_entry.row);
	assign raddr      = base_q + ADDR_W'(row_q);

	// memory: writes come in queue order, reads only while a draw job runs
	always_ff @(posedge clk) begin
		if (q_pop && q_entry.is_write) store_q[ent_addr] <= q_entry.data;
		if (issue) begin
			rdata_s1 <= store_q[raddr];
			x_s1     <= job_x_q;
			y_s1     <= 13'(job_y_q) + 13'(row_q);
			color_s1 <= job_color_q;
			last_s1  <= last_issue;
		end
		if (q_pop && !q_entry.is_write) begin
			job_h_q     <= q_entry.height;
			base_q      <= ent_addr;
			job_x_q     <= q_entry.x;
			job_y_q     <= q_entry.y;
			job_color_q <= q_entry.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_active_q <= 1'b0;
			row_q        <= '0;
			v_s1         <= 1'b0;
		end else begin
			if (q_pop) begin
				job_active_q <= !q_entry.is_write;
				row_q        <= '0;
			end else if (issue) begin
				if (last_issue) job_active_q <= 1'b0;
				else            row_q <= row_q + 5'd1;
			end
			if (issue)              v_s1 <= 1'b1;
			else if (row_out.ready) v_s1 <= 1'b0;
		end
	end

	assign row_out.valid       = v_s1;
	assign row_out.pixel_x     = x_s1;
	assign row_out.pixel_y     = y_s1;
	assign row_out.row_bits    = rdata_s1;
	assign row_out.pixel_color = color_s1;
	assign row_out.last_row    = last_s1;

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_active_q |-> ({1'b0, row_q} < job_h_q))
		else $error("row counter ran past glyph height");

	a_draw_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		job_active_q |-> (job_h_q != 6'd0))
		else $error("draw job with zero rows");

	a_draw_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_entry.is_write) |=> (job_active_q && row_q == 5'd0))
		else $error("popped draw job did not start at row zero");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && row_out.ready && last_s1 && !job_active_q) |=> !v_s1 || !last_s1
		|| $past(issue))
		else $error("last row repeated without a new job");

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_cyrillic_glyph_renderer.sv =====
// utf8_cyrillic_glyph_renderer: top level of the bitmap font glyph renderer
// depends on ucgr_pkg, ucgr_ifs, ucgr_front, ucgr_queue, ucgr_back
//
//  channel   dir  carries
//  text_in   in   font row loads, string begins, utf-8 text bytes
//  row_out   out  one glyph row per item: position, pixel bits, colour
//  cfg       in   register writes: glyph_height, screen_width
//
// text_in takes one item per cycle while the 4-entry job queue has room.
// a drawn glyph gives h rows, h = min(glyph_height, 32, MAX_GLYPH_ROWS), one
// row per cycle from the single glyph memory read port unless row_out stalls.
// the glyph memory is not cleared by reset; control state resets on arst_n.
// row_out stalls hold the sequencer; the queue lets text_in run on meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module utf8_cyrillic_glyph_renderer import ucgr_pkg::*; #(
	parameter int MAX_GLYPH_ROWS = DEF_MAX_GLYPH_ROWS,
	parameter int GLYPH_COUNT    = DEF_GLYPH_COUNT
) (
	input  wire        clk,
	input  wire        arst_n,
	ucgr_in_if.sink    text_in,
	ucgr_out_if.source row_out,
	ucgr_cfg_if.sink   cfg
);

	logic     push, q_not_full, pop, q_not_empty;
	q_entry_t push_entry, head;

	ucgr_front #(
		.MAX_GLYPH_ROWS(MAX_GLYPH_ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.cfg     (cfg),
		.q_ready (q_not_full),
		.q_push  (push),
		.q_entry (push_entry)
	);

	ucgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (q_not_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	ucgr_back #(
		.MAX_GLYPH_ROWS(MAX_GLYPH_ROWS),
		.GLYPH_COUNT   (GLYPH_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_entry (head),
		.q_pop   (pop),
		.row_out (row_out)
	);

endmodule

`default_nettype wire

// ===== verif/ucgr_row_checker.sv =====
// ucgr_row_checker: watches the text, row and register channels of the glyph renderer,
// predicts every glyph row and compares it field by field; depends on ucgr_pkg, ucgr_ifs
`timescale 1ns / 1ps
`default_nettype none

module ucgr_row_checker import ucgr_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_GLYPH_ROWS,
	parameter int GLYPHS   = DEF_GLYPH_COUNT
) (
	input  wire  clk,
	input  wire  arst_n,
	ucgr_in_if   text_in,
	ucgr_out_if  row_out,
	ucgr_cfg_if  cfg,
	output int   mismatches,
	output int   rows_owed
);

	localparam int FONT_DEPTH = GLYPHS * MAX_ROWS;
	localparam int ADVANCE    = 8;

	// utf-8 two-byte lead tag and the cyrillic leads d0/d1 (low five bits)
	localparam logic [2:0] LEAD_TAG = 3'b110;
	localparam logic [4:0] LEAD_D0  = 5'h10;
	localparam logic [4:0] LEAD_D1  = 5'h11;

	// code page layout of the remapped cyrillic glyphs
	localparam int LO_SPLIT    = 16;
	localparam int CP_UPPER    = 128;
	localparam int CP_LOWER    = 224;
	localparam int LO_YO_CAP   = 1;
	localparam int LO_YO_SMALL = 17;
	localparam int CP_YO_CAP   = 240;
	localparam int CP_YO_SMALL = 241;

	typedef struct packed {
		logic [11:0] x;
		logic [12:0] y;
		logic [7:0]  bits;
		logic [31:0] color;
		logic        last;
	} glyph_row_t;

	logic [7:0]  font_mem [FONT_DEPTH];
	logic [5:0]  height;
	logic [12:0] scr_width;
	logic [12:0] cur_x;
	logic [11:0] cur_y;
	logic [31:0] ink;
	logic        lead_wait;
	logic [7:0]  lead_char;
	logic        no_string;
	glyph_row_t  rows_due [$];
	glyph_row_t  oldest;
	int          fail_count = 0;
	int          owed_count = 0;

	assign mismatches = fail_count;
	assign rows_owed  = owed_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: row mismatch on %s, got 0x%0h expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic void render_glyph(input int code);
		int rows;
		glyph_row_t row_item;
		rows = height;
		if (rows > MAX_ROWS)
			rows = MAX_ROWS;
		if (rows > ROW_CAP)
			rows = ROW_CAP;
		if (code >= GLYPHS)
			return;
		for (int r = 0; r < rows; r++) begin
			row_item.x     = cur_x[11:0];
			row_item.y     = 13'(cur_y + r);
			row_item.bits  = font_mem[(code * MAX_ROWS + r) % FONT_DEPTH];
			row_item.color = ink;
			row_item.last  = (r == rows - 1);
			rows_due.push_back(row_item);
		end
	endfunction

	function automatic void render_text(input logic [7:0] ch, input logic eot);
		logic [4:0] hi;
		logic [5:0] lo;
		int         code;
		if (no_string)
			return;
		if (lead_wait) begin
			// second byte of a pair, consumed whatever it holds and never clipped
			lead_wait = 1'b0;
			hi = lead_char[4:0];
			lo = ch[5:0];
			if (hi == LEAD_D0 || hi == LEAD_D1) begin
				if (lo < LO_SPLIT)
					code = (lo == LO_YO_CAP && hi == LEAD_D0) ? CP_YO_CAP : CP_LOWER + lo;
				else
					code = (lo == LO_YO_SMALL && hi == LEAD_D1) ? CP_YO_SMALL :
						CP_UPPER + lo - LO_SPLIT;
				render_glyph(code);
			end
			cur_x = cur_x + 13'(ADVANCE);
			if (eot)
				no_string = 1'b1;
		end else if (int'(cur_x) + ADVANCE > int'(scr_width)) begin
			no_string = 1'b1;
		end else if (ch[7:5] == LEAD_TAG) begin
			if (eot) begin
				no_string = 1'b1;
			end else begin
				lead_wait = 1'b1;
				lead_char = ch;
			end
		end else if (ch == '0) begin
			no_string = 1'b1;
		end else begin
			if (!ch[7])
				render_glyph(ch);
			cur_x = cur_x + 13'(ADVANCE);
			if (eot)
				no_string = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height     = RST_GLYPH_HEIGHT;
			scr_width  = RST_SCREEN_WIDTH;
			cur_x      = '0;
			cur_y      = '0;
			ink        = '0;
			lead_wait  = 1'b0;
			lead_char  = '0;
			no_string  = 1'b1;
			rows_due.delete();
			owed_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_GLYPH_HEIGHT: height = cfg.data[5:0];
					REG_SCREEN_WIDTH: scr_width = cfg.data;
					default: ;
				endcase
			end
			if (text_in.valid && text_in.ready) begin
				case (text_in.op)
					OP_LOAD_ROW: begin
						if (text_in.glyph_row < MAX_ROWS)
							font_mem[(int'(text_in.glyph_index) * MAX_ROWS +
								int'(text_in.glyph_row)) % FONT_DEPTH] = text_in.font_row_bits;
					end
					OP_BEGIN: begin
						cur_x     = 13'(text_in.start_x);
						cur_y     = text_in.start_y;
						ink       = text_in.text_color;
						lead_wait = 1'b0;
						lead_char = '0;
						no_string = 1'b0;
					end
					OP_TEXT: render_text(text_in.text_byte, text_in.end_of_text);
					default: ;
				endcase
			end
			if (row_out.valid && row_out.ready) begin
				if (rows_due.size() == 0) begin
					report_mismatch("row with nothing expected, pixel_x", row_out.pixel_x, '0);
				end else begin
					oldest = rows_due.pop_front();
					if (row_out.pixel_x !== oldest.x)
						report_mismatch("pixel_x", row_out.pixel_x, oldest.x);
					if (row_out.pixel_y !== oldest.y)
						report_mismatch("pixel_y", row_out.pixel_y, oldest.y);
					if (row_out.row_bits !== oldest.bits)
						report_mismatch("row_bits", row_out.row_bits, oldest.bits);
					if (row_out.pixel_color !== oldest.color)
						report_mismatch("pixel_color", row_out.pixel_color, oldest.color);
					if (row_out.last_row !== oldest.last)
						report_mismatch("last_row", row_out.last_row, oldest.last);
				end
			end
			owed_count = rows_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== verif/utf8_cyrillic_glyph_renderer_tb.sv =====
// utf8_cyrillic_glyph_renderer_tb: loads the glyphs it draws, then drives directed and random
// utf-8 strings under several font shapes and stall patterns; depends on ucgr_pkg,
// ucgr_ifs, ucgr_row_checker and the renderer rtl
`timescale 1ns / 1ps
`default_nettype none

module utf8_cyrillic_glyph_renderer_tb;
	import ucgr_pkg::*;

	localparam int MAX_ROWS = DEF_MAX_GLYPH_ROWS;
	localparam int GLYPHS   = DEF_GLYPH_COUNT;

	// op three carries nothing and must be dropped
	localparam logic [1:0] OP_IDLE = 2'd3;

	localparam int SETTLE_CYCLES = 200;
	localparam int DRAIN_LIMIT   = 100000;
	localparam int N_SHAPES      = 6;

	// the directed part draws short glyphs, random strings only fully loaded ones
	localparam int DIRECTED_H = 2;
	localparam int N_FULL     = 3;
	localparam int N_SHORT    = 6;

	localparam logic [7:0] G_ASCII    = 8'h41;
	localparam logic [7:0] LEAD_D0    = 8'hD0;
	localparam logic [7:0] LEAD_D1    = 8'hD1;
	// d0 90 maps to glyph 128, d1 80 to glyph 224
	localparam logic [7:0] CONT_UPPER = 8'h90;
	localparam logic [7:0] CONT_LOWER = 8'h80;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  glyph_index;
		logic [4:0]  glyph_row;
		logic [7:0]  font_row_bits;
		logic [11:0] start_x;
		logic [11:0] start_y;
		logic [31:0] text_color;
		logic [7:0]  text_byte;
		logic        end_of_text;
	} text_item_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   rows_owed;
	int   src_idle = 0;
	int   snk_idle = 0;

	// font shapes swept after the directed part, the last one is drawn at random
	int shape_h [N_SHAPES]     = '{1, 32, 0, 63, 5, 16};
	int shape_w [N_SHAPES]     = '{8, 4096, 8191, 1000, 0, 640};
	int shape_items [N_SHAPES] = '{14, 14, 10, 14, 8, 25};

	// glyphs with every row loaded, and glyphs loaded only for the directed height
	int full_glyphs [N_FULL]   = '{8'h41, 128, 224};
	int short_glyphs [N_SHORT] = '{8'h7F, 8'h01, 240, 241, 175, 8'h7E};

	ucgr_in_if  text_in();
	ucgr_out_if row_out();
	ucgr_cfg_if cfg();

	utf8_cyrillic_glyph_renderer #(
		.MAX_GLYPH_ROWS(MAX_ROWS),
		.GLYPH_COUNT   (GLYPHS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text_in(text_in),
		.row_out(row_out),
		.cfg    (cfg)
	);

	ucgr_row_checker #(
		.MAX_ROWS(MAX_ROWS),
		.GLYPHS  (GLYPHS)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.row_out   (row_out),
		.cfg       (cfg),
		.mismatches(mismatches),
		.rows_owed (rows_owed)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(negedge clk) begin
		row_out.ready = ($urandom_range(0, 99) >= snk_idle);
	end

	function automatic text_item_t noise_item();
		text_item_t it;
		it.op            = 2'($urandom);
		it.glyph_index   = 8'($urandom);
		it.glyph_row     = 5'($urandom);
		it.font_row_bits = 8'($urandom);
		it.start_x       = 12'($urandom);
		it.start_y       = 12'($urandom);
		it.text_color    = $urandom;
		it.text_byte     = 8'($urandom);
		it.end_of_text   = 1'($urandom);
		return it;
	endfunction

	function automatic text_item_t char_item(input logic [7:0] ch, input logic eot);
		text_item_t it;
		it             = noise_item();
		it.op          = OP_TEXT;
		it.text_byte   = ch;
		it.end_of_text = eot;
		return it;
	endfunction

	function automatic text_item_t begin_item(input logic [11:0] sx, input logic [11:0] sy,
		input logic [31:0] col);
		text_item_t it;
		it            = noise_item();
		it.op         = OP_BEGIN;
		it.start_x    = sx;
		it.start_y    = sy;
		it.text_color = col;
		return it;
	endfunction

	function automatic text_item_t load_item(input logic [7:0] g, input logic [4:0] r,
		input logic [7:0] bits);
		text_item_t it;
		it               = noise_item();
		it.op            = OP_LOAD_ROW;
		it.glyph_index   = g;
		it.glyph_row     = r;
		it.font_row_bits = bits;
		return it;
	endfunction

	// a high byte that is no lead and draws nothing alone
	function automatic logic [7:0] lone_high();
		logic [7:0] ch;
		if ($urandom_range(0, 1))
			ch = 8'($urandom_range(8'h80, 8'hBF));
		else
			ch = 8'($urandom_range(8'hE0, 8'hFF));
		return ch;
	endfunction

	// a two-byte lead other than d0/d1
	function automatic logic [7:0] other_lead();
		logic [7:0] ch;
		if ($urandom_range(0, 1))
			ch = 8'($urandom_range(8'hC0, 8'hCF));
		else
			ch = 8'($urandom_range(8'hD2, 8'hDF));
		return ch;
	endfunction

	function automatic logic [7:0] stray_byte();
		logic [7:0] ch;
		case ($urandom_range(0, 2))
			0:       ch = G_ASCII;
			1:       ch = lone_high();
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send(input text_item_t it);
		while ($urandom_range(0, 99) < src_idle) begin
			text_in.valid = 1'b0;
			@(negedge clk);
		end
		text_in.valid         = 1'b1;
		text_in.op            = it.op;
		text_in.glyph_index   = it.glyph_index;
		text_in.glyph_row     = it.glyph_row;
		text_in.font_row_bits = it.font_row_bits;
		text_in.start_x       = it.start_x;
		text_in.start_y       = it.start_y;
		text_in.text_color    = it.text_color;
		text_in.text_byte     = it.text_byte;
		text_in.end_of_text   = it.end_of_text;
		@(posedge clk);
		while (!text_in.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic set_font_shape(input int h, input int w);
		// bits above the six height bits carry junk on purpose
		write_reg(REG_GLYPH_HEIGHT, {7'($urandom), 6'(h)});
		write_reg(REG_SCREEN_WIDTH, 13'(w));
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		text_in.valid = 1'b0;
		while (rows_owed != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		// loads may still sit in the job queue
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_strings(input int budget);
		int         sent;
		int         kind;
		int         n_chars;
		int         pick;
		logic       eot;
		logic [11:0] sx;
		logic [11:0] sy;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 80) begin
				pick = $urandom_range(0, 9);
				sx = (pick < 2) ? 12'd0 : (pick < 7) ? 12'($urandom_range(0, 160)) :
					12'($urandom);
				sy = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 64));
				send(begin_item(sx, sy, $urandom));
				sent++;
				n_chars = $urandom_range(1, 10);
				for (int c = 0; c < n_chars; c++) begin
					eot = (c == n_chars - 1) && ($urandom_range(0, 1) == 1);
					kind = $urandom_range(0, 99);
					if (kind < 50) begin
						send(char_item(G_ASCII, eot));
					end else if (kind < 80) begin
						if ($urandom_range(0, 1)) begin
							send(char_item(LEAD_D0, 1'b0));
							send(char_item(CONT_UPPER, eot));
						end else begin
							send(char_item(LEAD_D1, 1'b0));
							send(char_item(CONT_LOWER, eot));
						end
						sent++;
					end else if (kind < 88) begin
						// a lead other than d0/d1, now and then marked last, then any byte
						send(char_item(other_lead(), $urandom_range(0, 19) == 0));
						send(char_item(8'($urandom), eot));
						sent++;
					end else if (kind < 95) begin
						send(char_item(lone_high(), eot));
					end else begin
						send(char_item(8'h00, eot));
					end
					sent++;
				end
			end else if (kind < 88) begin
				send(load_item(8'($urandom), 5'($urandom), 8'($urandom)));
				sent++;
			end else if (kind < 93) begin
				send(char_item(stray_byte(), 1'($urandom)));
				sent++;
			end else if (kind < 97) begin
				send(begin_item(12'($urandom), 12'($urandom), $urandom));
				sent++;
			end else begin
				text_item_t it;
				it = noise_item();
				it.op = OP_IDLE;
				send(it);
			end
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		text_in.valid         = 1'b0;
		text_in.op            = OP_LOAD_ROW;
		text_in.glyph_index   = '0;
		text_in.glyph_row     = '0;
		text_in.font_row_bits = '0;
		text_in.start_x       = '0;
		text_in.start_y       = '0;
		text_in.text_color    = '0;
		text_in.text_byte     = '0;
		text_in.end_of_text   = 1'b0;
		row_out.ready         = 1'b0;
		cfg.valid             = 1'b0;
		cfg.index             = REG_GLYPH_HEIGHT;
		cfg.data              = '0;
		src_idle              = 13;
		snk_idle              = 45;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_font_shape(DIRECTED_H, 640);
		// every glyph that is drawn gets its rows before anything is drawn
		for (int g = 0; g < N_FULL; g++)
			for (int r = 0; r < MAX_ROWS; r++)
				send(load_item(8'(full_glyphs[g]), 5'(r), 8'($urandom)));
		for (int g = 0; g < N_SHORT; g++)
			for (int r = 0; r < DIRECTED_H; r++)
				send(load_item(8'(short_glyphs[g]), 5'(r), 8'($urandom)));

		send(begin_item(12'd0, 12'd0, 32'hFFFF_FFFF));
		send(char_item(8'h41, 1'b0));
		send(char_item(8'h7F, 1'b0));
		send(char_item(8'h01, 1'b0));
		// capital and small yo, then the top end of the range from 128
		send(char_item(8'hD0, 1'b0));
		send(char_item(8'h81, 1'b0));
		send(char_item(8'hD1, 1'b0));
		send(char_item(8'h91, 1'b0));
		send(char_item(8'hD0, 1'b0));
		send(char_item(8'hBF, 1'b0));
		// non-cyrillic pair and lone high byte advance without drawing
		send(char_item(8'hC3, 1'b0));
		send(char_item(8'hA9, 1'b0));
		send(char_item(8'hFF, 1'b0));
		// nul taken as a continuation
		send(char_item(8'hD0, 1'b0));
		send(char_item(8'h00, 1'b0));
		// pending lead dropped by a new string, then a fit at the edge and a clip
		send(char_item(8'hDF, 1'b0));
		send(begin_item(12'd632, 12'd4095, 32'h0));
		send(char_item(8'h7E, 1'b0));
		send(char_item(8'h42, 1'b0));
		send(begin_item(12'd8, 12'd8, 32'hA5A5_A5A5));
		send(char_item(8'hD0, 1'b1));
		send(char_item(8'h78, 1'b0));
		send(begin_item(12'd16, 12'd16, 32'h1234_5678));
		send(char_item(8'h00, 1'b0));
		begin
			text_item_t it;
			it = noise_item();
			it.op = OP_IDLE;
			send(it);
		end
		wait_drained();

		for (int s = 0; s < N_SHAPES; s++) begin
			if (s == 2) begin
				src_idle = 45;
				snk_idle = 13;
			end
			if (s == 4) begin
				src_idle = 0;
				snk_idle = 0;
			end
			if (s == N_SHAPES - 1)
				set_font_shape($urandom_range(1, 31), $urandom_range(8, 4096));
			else
				set_font_shape(shape_h[s], shape_w[s]);
			random_strings(shape_items[s]);
			wait_drained();
		end

		if (rows_owed != 0)
			$display("%0d glyph rows never arrived", rows_owed);
		if (mismatches == 0 && rows_owed == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("run timed out");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ucgr_pkg.sv
hw/rtl/ucgr_ifs.sv
hw/rtl/ucgr_front.sv
hw/rtl/ucgr_queue.sv
hw/rtl/ucgr_back.sv
hw/rtl/utf8_cyrillic_glyph_renderer.sv
verif/ucgr_row_checker.sv
verif/utf8_cyrillic_glyph_renderer_tb.sv
